// ----- hw/rtl/wast_pkg.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm schedule table: shared definitions
// Widths, constants, codes, state encoding and the structs that pass
// between the sequencer, the table storage and the distance unit.
// ----------------------------------------------------------------------------
package wast_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ACTION_W    = 2;
  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int MASK_W      = 7;
  localparam int INDEX_IN_W  = 8;
  localparam int DAY_W       = 3;
  localparam int CODE_W      = 3;
  localparam int COUNT_OUT_W = 4;
  localparam int NEXT_IDX_W  = 3;

  localparam int DAYS_PER_WEEK = 7;
  localparam int DAY_SLOTS     = 8;
  localparam int MIN_PER_HOUR  = 60;
  localparam int MIN_PER_DAY   = 1440;
  localparam int MAX_HOUR      = 23;
  localparam int MAX_MINUTE    = 59;
  localparam int DIST_W        = 14;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_TIME_SYNCED = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    RC_OK             = 3'd0,
    RC_NOT_SYNCED     = 3'd1,
    RC_FULL           = 3'd2,
    RC_BAD_FORMAT     = 3'd3,
    RC_DUPLICATE      = 3'd4,
    RC_ACTION_CHANGED = 3'd5,
    RC_BAD_INDEX      = 3'd6
  } result_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP,
    ST_SHIFT,
    ST_TICK,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MASK_W-1:0]   day_mask;
    logic                turn_on;
  } alarm_entry_t;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [HOUR_W-1:0]     entry_hour;
    logic [MINUTE_W-1:0]   entry_minute;
    logic [MASK_W-1:0]     day_mask;
    logic                  turn_on;
    logic [INDEX_IN_W-1:0] entry_index;
    logic [DAY_W-1:0]      now_weekday;
    logic [HOUR_W-1:0]     now_hour;
    logic [MINUTE_W-1:0]   now_minute;
  } item_t;

  typedef struct packed {
    logic [DAY_W-1:0]    weekday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } now_t;

  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] distance;
  } dist_res_t;

  typedef struct packed {
    logic         we;
    logic [IDX_W-1:0] waddr;
    alarm_entry_t wdata;
    logic [IDX_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic                   valid;
    logic [CODE_W-1:0]      result_code;
    logic                   relay_fire;
    logic                   relay_on;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   next_valid;
    logic [NEXT_IDX_W-1:0]  next_index;
  } result_t;

endpackage

// ----- hw/rtl/wast_mem.sv -----
// ----------------------------------------------------------------------------
// Alarm table storage
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module wast_mem (
  input  logic                    clk,
  input  wast_pkg::mem_cmd_t      cmd,
  output wast_pkg::alarm_entry_t  rd_entry
);
  import wast_pkg::*;

  alarm_entry_t mem [TABLE_DEPTH];
  alarm_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rd_entry_r <= mem[cmd.raddr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ----- hw/rtl/wast_dist.sv -----
// ----------------------------------------------------------------------------
// Alarm distance unit
// Gives the number of minutes from now to the next occurrence of one entry,
// strictly in the future, or no result when the entry never occurs.
// ----------------------------------------------------------------------------
module wast_dist (
  input  wast_pkg::alarm_entry_t entry,
  input  wast_pkg::now_t         now_time,
  output wast_pkg::dist_res_t    res
);
  import wast_pkg::*;

  logic [DIST_W-1:0]    ent_min;
  logic [DIST_W-1:0]    now_min;
  logic [DIST_W-1:0]    day_off;
  logic [MASK_W-1:0]    rot_mask;
  logic [DAY_SLOTS-1:0] cand;
  logic [DAY_W-1:0]     day_sel;

  assign ent_min = DIST_W'(entry.hour) * DIST_W'(MIN_PER_HOUR) + DIST_W'(entry.minute);
  assign now_min = DIST_W'(now_time.hour) * DIST_W'(MIN_PER_HOUR)
                 + DIST_W'(now_time.minute);

  // Bit k of the rotated mask is the weekday k days from today.
  assign rot_mask = MASK_W'({entry.day_mask, entry.day_mask} >> now_time.weekday);

  // Today and tomorrow need the time check; the clock may read past midnight,
  // so tomorrow is not always later. Two days ahead and beyond always are.
  always_comb begin
    cand    = {rot_mask[0], rot_mask[MASK_W-1:2], 2'b00};
    cand[0] = rot_mask[0] && (ent_min > now_min);
    cand[1] = rot_mask[1] && ((ent_min + DIST_W'(MIN_PER_DAY)) > now_min);
  end

  always_comb begin
    day_sel = '0;
    for (int k = DAY_SLOTS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        day_sel = DAY_W'(k);
      end
    end
  end

  assign day_off      = DIST_W'(day_sel) * DIST_W'(MIN_PER_DAY);
  assign res.ok       = |cand;
  assign res.distance = day_off + ent_min - now_min;

endmodule

// ----- hw/rtl/wast_ctrl.sv -----
// ----------------------------------------------------------------------------
// Alarm table sequencer
// Walks the table one entry a cycle for the duplicate search, the shift on
// delete and the choice of the pending alarm, and holds the result.
// ----------------------------------------------------------------------------
module wast_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  wast_pkg::item_t        item,
  input  logic                   synced,
  input  wast_pkg::alarm_entry_t rd_entry,
  input  wast_pkg::dist_res_t    dist_res,
  output logic                   busy,
  output wast_pkg::mem_cmd_t     mem_cmd,
  output wast_pkg::now_t         now_time,
  output wast_pkg::result_t      result
);
  import wast_pkg::*;

  state_t            state_r, state_nxt;
  item_t             req_r, req_nxt;
  result_code_t      code_r, code_nxt;
  logic              fire_r, fire_nxt;
  logic              level_r, level_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic              best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;

  logic             add_ok;
  logic             del_ok;
  logic             tick_rd;
  logic             scan_end;
  logic             dup_hit;
  logic             tick_hit;
  logic             better;
  logic [DAY_W-1:0] wday_in;

  assign wday_in  = (item.now_weekday == DAY_W'(DAYS_PER_WEEK)) ? '0 : item.now_weekday;
  assign add_ok   = synced && (count_r < CNT_W'(TABLE_DEPTH))
                 && (item.entry_hour <= HOUR_W'(MAX_HOUR))
                 && (item.entry_minute <= MINUTE_W'(MAX_MINUTE));
  assign del_ok   = item.entry_index < INDEX_IN_W'(count_r);
  assign tick_rd  = synced && pend_valid_r;
  assign scan_end = ptr_r == count_r;
  assign dup_hit  = (rd_entry.hour == req_r.entry_hour)
                 && (rd_entry.minute == req_r.entry_minute)
                 && (rd_entry.day_mask == req_r.day_mask);
  assign tick_hit = rd_entry.day_mask[req_r.now_weekday]
                 && (rd_entry.hour == req_r.now_hour)
                 && (rd_entry.minute == req_r.now_minute);
  assign better   = dist_res.ok && (!best_valid_r || (dist_res.distance < best_r));

  assign now_time.weekday = req_r.now_weekday;
  assign now_time.hour    = req_r.now_hour;
  assign now_time.minute  = req_r.now_minute;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (item.action)
            ACT_ADD:    state_nxt = add_ok ? ST_DUP : ST_DONE;
            ACT_DELETE: state_nxt = del_ok ? ST_SHIFT : ST_DONE;
            ACT_TICK:   state_nxt = tick_rd ? ST_TICK : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DUP: begin
        if (scan_end || dup_hit) begin
          state_nxt = ST_SCAN_INIT;
        end
      end
      ST_SHIFT: begin
        if (scan_end) begin
          state_nxt = ST_SCAN_INIT;
        end
      end
      ST_TICK:      state_nxt = tick_hit ? ST_SCAN_INIT : ST_DONE;
      ST_SCAN_INIT: state_nxt = synced ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and table access
  always_comb begin
    req_nxt        = req_r;
    code_nxt       = code_r;
    fire_nxt       = fire_r;
    level_nxt      = level_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    ptr_nxt        = ptr_r;
    best_nxt       = best_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    mem_cmd.we     = 1'b0;
    mem_cmd.waddr  = IDX_W'(ptr_r);
    mem_cmd.wdata  = rd_entry;
    mem_cmd.raddr  = IDX_W'(ptr_r + 1'b1);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt             = item;
          req_nxt.now_weekday = wday_in;
          code_nxt            = RC_OK;
          fire_nxt            = 1'b0;
          level_nxt           = 1'b0;
          ptr_nxt             = '0;
          mem_cmd.raddr       = '0;
          unique case (item.action)
            ACT_ADD: begin
              priority if (!synced) begin
                code_nxt = RC_NOT_SYNCED;
              end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                code_nxt = RC_FULL;
              end else if (!add_ok) begin
                code_nxt = RC_BAD_FORMAT;
              end
            end
            ACT_DELETE: begin
              if (del_ok) begin
                count_nxt     = count_r - 1'b1;
                ptr_nxt       = CNT_W'(item.entry_index);
                mem_cmd.raddr = IDX_W'(item.entry_index + 1'b1);
              end else begin
                code_nxt = RC_BAD_INDEX;
              end
            end
            ACT_TICK: begin
              mem_cmd.raddr = pend_idx_r;
            end
            default: begin
              code_nxt = RC_OK;
            end
          endcase
        end
      end
      ST_DUP: begin
        // The read data belongs to the entry at ptr_r.
        priority if (scan_end) begin
          mem_cmd.we     = 1'b1;
          mem_cmd.waddr  = IDX_W'(count_r);
          mem_cmd.wdata  = '{hour: req_r.entry_hour, minute: req_r.entry_minute,
                             day_mask: req_r.day_mask, turn_on: req_r.turn_on};
          count_nxt      = count_r + 1'b1;
          code_nxt       = RC_OK;
        end else if (dup_hit) begin
          if (rd_entry.turn_on != req_r.turn_on) begin
            mem_cmd.we            = 1'b1;
            mem_cmd.wdata.turn_on = req_r.turn_on;
            code_nxt              = RC_ACTION_CHANGED;
          end else begin
            code_nxt = RC_DUPLICATE;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        // The read data belongs to the entry above ptr_r.
        if (!scan_end) begin
          mem_cmd.we    = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
          mem_cmd.raddr = IDX_W'(ptr_r + CNT_W'(2));
        end
      end
      ST_TICK: begin
        if (tick_hit) begin
          fire_nxt  = 1'b1;
          level_nxt = rd_entry.turn_on;
        end
      end
      ST_SCAN_INIT: begin
        ptr_nxt        = '0;
        mem_cmd.raddr  = '0;
        best_valid_nxt = 1'b0;
        best_idx_nxt   = '0;
        if (!synced) begin
          pend_valid_nxt = 1'b0;
          pend_idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          pend_valid_nxt = best_valid_r;
          pend_idx_nxt   = best_valid_r ? best_idx_r : '0;
        end else begin
          if (better) begin
            best_nxt       = dist_res.distance;
            best_valid_nxt = 1'b1;
            best_idx_nxt   = IDX_W'(ptr_r);
          end
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_DONE: begin
        ptr_nxt = ptr_r;
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy               = state_r != ST_IDLE;
    result.valid       = state_r == ST_DONE;
    result.result_code = code_r;
    result.relay_fire  = fire_r;
    result.relay_on    = level_r;
    result.entry_count = COUNT_OUT_W'(count_r);
    result.next_valid  = pend_valid_r;
    result.next_index  = NEXT_IDX_W'(pend_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      code_r       <= RC_OK;
      fire_r       <= 1'b0;
      level_r      <= 1'b0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      pend_idx_r   <= '0;
      ptr_r        <= '0;
      best_valid_r <= 1'b0;
      best_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      code_r       <= code_nxt;
      fire_r       <= fire_nxt;
      level_r      <= level_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_idx_r   <= pend_idx_nxt;
      ptr_r        <= ptr_nxt;
      best_valid_r <= best_valid_nxt;
      best_idx_r   <= best_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    best_r <= best_nxt;
  end

endmodule

// ----- hw/rtl/weekly_alarm_schedule_table_unit.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm schedule table
// Holds up to eight weekly relay alarms, adds and deletes them, fires the
// relay on a matching tick and keeps the soonest future alarm as pending.
// ----------------------------------------------------------------------------
//  Channel  | Ports                         | Handshake
//  ---------+-------------------------------+---------------------------------
//  item in  | start, busy, in_*             | taken when start and not busy
//  result   | out_valid, out_*              | one-cycle strobe, no back-pressure
//  config   | psel, penable, pwrite, paddr, | APB write, pready tied high
//           | pwdata, prdata, pready        |
//
// Every item gives exactly one result. Add walks the table for a duplicate,
// delete shifts the later entries down, and after an add or a delete that
// is taken, or a firing tick, the pending alarm is chosen by a pass through
// the shared distance unit, one entry per cycle, since the table has one
// read port. An add is the longest case; rejected items go straight to the
// result, and a tick that does not fire reads only the pending entry.
// Reset clears the entry count, the pending alarm and the sync register.
// ----------------------------------------------------------------------------
module weekly_alarm_schedule_table_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [wast_pkg::ACTION_W-1:0]        in_action,
  input  logic [wast_pkg::HOUR_W-1:0]          in_entry_hour,
  input  logic [wast_pkg::MINUTE_W-1:0]        in_entry_minute,
  input  logic [wast_pkg::MASK_W-1:0]          in_day_mask,
  input  logic                                 in_turn_on,
  input  logic [wast_pkg::INDEX_IN_W-1:0]      in_entry_index,
  input  logic [wast_pkg::DAY_W-1:0]           in_now_weekday,
  input  logic [wast_pkg::HOUR_W-1:0]          in_now_hour,
  input  logic [wast_pkg::MINUTE_W-1:0]        in_now_minute,
  output logic                                 out_valid,
  output logic [wast_pkg::CODE_W-1:0]          out_result_code,
  output logic                                 out_relay_fire,
  output logic                                 out_relay_on,
  output logic [wast_pkg::COUNT_OUT_W-1:0]     out_entry_count,
  output logic                                 out_next_valid,
  output logic [wast_pkg::NEXT_IDX_W-1:0]      out_next_index,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wast_pkg::APB_AW-1:0]          paddr,
  input  logic [wast_pkg::APB_DW-1:0]          pwdata,
  output logic [wast_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import wast_pkg::*;

  logic         synced_r, synced_nxt;
  logic         cfg_wr;
  item_t        item;
  alarm_entry_t rd_entry;
  dist_res_t    dist_res;
  mem_cmd_t     mem_cmd;
  now_t         now_time;
  result_t      result;

  // Registers sit on word addresses; the byte offset bits are ignored.
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign synced_nxt = (cfg_wr && (paddr[APB_AW-1] == REG_TIME_SYNCED)) ? pwdata[0] : synced_r;
  assign prdata     = (paddr[APB_AW-1] == REG_TIME_SYNCED)
                    ? {{(APB_DW-1){1'b0}}, synced_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r <= 1'b0;
    end else begin
      synced_r <= synced_nxt;
    end
  end

  assign item.action       = in_action;
  assign item.entry_hour   = in_entry_hour;
  assign item.entry_minute = in_entry_minute;
  assign item.day_mask     = in_day_mask;
  assign item.turn_on      = in_turn_on;
  assign item.entry_index  = in_entry_index;
  assign item.now_weekday  = in_now_weekday;
  assign item.now_hour     = in_now_hour;
  assign item.now_minute   = in_now_minute;

  wast_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (item),
    .synced   (synced_r),
    .rd_entry (rd_entry),
    .dist_res (dist_res),
    .busy     (busy),
    .mem_cmd  (mem_cmd),
    .now_time (now_time),
    .result   (result)
  );

  wast_mem u_mem (
    .clk      (clk),
    .cmd      (mem_cmd),
    .rd_entry (rd_entry)
  );

  wast_dist u_dist (
    .entry    (rd_entry),
    .now_time (now_time),
    .res      (dist_res)
  );

  assign out_valid       = result.valid;
  assign out_result_code = result.result_code;
  assign out_relay_fire  = result.relay_fire;
  assign out_relay_on    = result.relay_on;
  assign out_entry_count = result.entry_count;
  assign out_next_valid  = result.next_valid;
  assign out_next_index  = result.next_index;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result presented while the block was ready for a new item");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_next_valid) |-> (out_next_index == '0))
    else $error("pending index not cleared with no pending alarm");

  a_level_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_relay_fire) |-> !out_relay_on)
    else $error("relay level driven without a firing item");

endmodule
